### hw/rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, result codes and character constants of the S-record parser.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int unsigned KIND_W  = 3;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned POS_W   = 10;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ENTRY     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BAD_START = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAD_TYPE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DATA_OVF  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ENTRY_OVF = 3'd5;
	localparam logic [KIND_W-1:0] KIND_BAD_COUNT = 3'd6;

	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_LF   = 8'h0a;

	localparam logic [POS_W-1:0] POS_START = 10'd0;
	localparam logic [POS_W-1:0] POS_TYPE  = 10'd1;
	localparam logic [POS_W-1:0] POS_CNT_H = 10'd2;
	localparam logic [POS_W-1:0] POS_CNT_L = 10'd3;
	localparam logic [POS_W-1:0] POS_ADDR  = 10'd4;
	localparam logic [POS_W-1:0] POS_MAX   = 10'd1023;

	localparam logic [7:0]  MIN_COUNT     = 8'd3;
	localparam logic [31:0] MEM_LIMIT_RST = 32'd128000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] target_address;
		logic [DATA_W-1:0] write_data;
	} result_t;

	typedef struct packed {
		logic    valid;
		logic    halted;
		result_t res;
	} core_out_t;

	// non-hex characters decode as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
		return v;
	endfunction

endpackage

### hw/rtl/slp_if.sv
// ----------------------------------------------------------------------------
// slp_char_if / slp_result_if
// Valid/ready channels for characters in and parser results out.
// ----------------------------------------------------------------------------
interface slp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

interface slp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] target_address;
	logic [7:0]  write_data;

	modport source(output valid, output kind, output target_address, output write_data,
		input ready);
	modport sink(input valid, input kind, input target_address, input write_data,
		output ready);
endinterface

### hw/rtl/slp_core.sv
// ----------------------------------------------------------------------------
// slp_core
// Per-line parser state and the per-character next-state and result logic.
// ----------------------------------------------------------------------------
module slp_core #(
	parameter int unsigned ADDR_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	input  logic [31:0]       memory_limit,
	output slp_pkg::core_out_t core_out
);
	import slp_pkg::*;

	logic                  halted_q, halted_n;
	logic [POS_W-1:0]      pos_q, pos_n;
	logic [7:0]            rkind_q, rkind_n;
	logic [7:0]            bcount_q, bcount_n;
	logic [ADDR_WIDTH-1:0] acc_q, acc_n;
	logic [2:0]            alen_q, alen_n;
	logic [3:0]            hi_q, hi_n;
	logic [7:0]            didx_q, didx_n;
	logic                  skip_q, skip_n;

	logic [3:0]            nib;
	logic [7:0]            cnt_byte;
	logic [POS_W-1:0]      q;
	logic [POS_W-1:0]      alen2;
	logic [POS_W-1:0]      r;
	logic                  in_addr;
	logic                  last_addr;
	logic                  is_data;
	logic [7:0]            alen_p1;
	logic [7:0]            count;
	logic [ADDR_WIDTH-1:0] acc_sh;
	logic [31:0]           acc_sh_ext;
	logic [32:0]           end_addr;
	logic [31:0]           waddr;
	logic                  res_vld;
	result_t               res;

	assign nib        = hex_value(ch);
	assign cnt_byte   = {hi_q, nib};
	assign q          = pos_q - POS_ADDR;
	assign alen2      = {6'd0, alen_q, 1'b0};
	assign r          = q - alen2;
	assign in_addr    = q < alen2;
	assign last_addr  = q == (alen2 - 10'd1);
	assign is_data    = rkind_q >= 8'd1 && rkind_q <= 8'd3;
	assign alen_p1    = {5'd0, alen_q} + 8'd1;
	assign count      = (bcount_q >= alen_p1) ? (bcount_q - alen_p1) : 8'd0;
	assign acc_sh     = {acc_q[ADDR_WIDTH-5:0], nib};
	assign acc_sh_ext = 32'(acc_sh);
	assign end_addr   = {1'b0, acc_sh_ext} + {25'd0, count};
	assign waddr      = 32'(acc_q) + {24'd0, didx_q};

	always_comb begin
		halted_n = halted_q;
		pos_n    = pos_q;
		rkind_n  = rkind_q;
		bcount_n = bcount_q;
		acc_n    = acc_q;
		alen_n   = alen_q;
		hi_n     = hi_q;
		didx_n   = didx_q;
		skip_n   = skip_q;
		res_vld  = 1'b0;
		res      = '0;
		if (!halted_q) begin
			priority if (pos_q == POS_START) begin
				if (ch != CHAR_S) begin
					res_vld  = 1'b1;
					res.kind = KIND_BAD_START;
					halted_n = 1'b1;
				end else begin
					pos_n = POS_TYPE;
				end
			end else if (pos_q == POS_TYPE) begin
				if (ch < CHAR_ZERO) begin
					res_vld  = 1'b1;
					res.kind = KIND_BAD_TYPE;
					halted_n = 1'b1;
				end else begin
					rkind_n = ch - CHAR_ZERO;
					pos_n   = POS_CNT_H;
				end
			end else if (ch == CHAR_LF) begin
				// line cut short before its count
				if (pos_q < POS_ADDR && !skip_q) begin
					res_vld  = 1'b1;
					res.kind = KIND_BAD_COUNT;
				end
				pos_n    = POS_START;
				rkind_n  = '0;
				bcount_n = '0;
				acc_n    = '0;
				alen_n   = '0;
				hi_n     = '0;
				didx_n   = '0;
				skip_n   = 1'b0;
			end else begin
				if (!skip_q) begin
					priority if (pos_q == POS_CNT_H) begin
						hi_n = nib;
					end else if (pos_q == POS_CNT_L) begin
						bcount_n = cnt_byte;
						if (cnt_byte < MIN_COUNT) begin
							res_vld  = 1'b1;
							res.kind = KIND_BAD_COUNT;
							skip_n   = 1'b1;
						end else begin
							unique case (rkind_q)
								8'd1, 8'd9: alen_n = 3'd2;
								8'd2, 8'd8: alen_n = 3'd3;
								8'd3, 8'd7: alen_n = 3'd4;
								default: begin
									alen_n = 3'd0;
									skip_n = 1'b1;
								end
							endcase
						end
					end else if (in_addr) begin
						acc_n = acc_sh;
						if (last_addr) begin
							if (is_data) begin
								if (end_addr > {1'b0, memory_limit}) begin
									res_vld  = 1'b1;
									res.kind = KIND_DATA_OVF;
									halted_n = 1'b1;
								end
							end else if (acc_sh_ext >= memory_limit) begin
								res_vld  = 1'b1;
								res.kind = KIND_ENTRY_OVF;
								halted_n = 1'b1;
							end else begin
								res_vld            = 1'b1;
								res.kind           = KIND_ENTRY;
								res.target_address = acc_sh_ext;
								skip_n             = 1'b1;
							end
						end
					end else if (!r[0]) begin
						hi_n = nib;
					end else begin
						if (didx_q < count) begin
							res_vld            = 1'b1;
							res.kind           = KIND_WRITE;
							res.target_address = waddr;
							res.write_data     = cnt_byte;
							didx_n             = didx_q + 8'd1;
						end
					end
				end
				if (pos_q < POS_MAX) pos_n = pos_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			pos_q    <= '0;
			rkind_q  <= '0;
			bcount_q <= '0;
			acc_q    <= '0;
			alen_q   <= '0;
			hi_q     <= '0;
			didx_q   <= '0;
			skip_q   <= 1'b0;
		end else if (step) begin
			halted_q <= halted_n;
			pos_q    <= pos_n;
			rkind_q  <= rkind_n;
			bcount_q <= bcount_n;
			acc_q    <= acc_n;
			alen_q   <= alen_n;
			hi_q     <= hi_n;
			didx_q   <= didx_n;
			skip_q   <= skip_n;
		end
	end

	assign core_out.valid  = res_vld;
	assign core_out.halted = halted_q;
	assign core_out.res    = res;

endmodule

### hw/rtl/srecord_loader_parser.sv
// ----------------------------------------------------------------------------
// srecord_loader_parser
// S-record text parser: one character in, at most one memory write, entry
// point or error result out.
// ----------------------------------------------------------------------------
// pipeline: an accepted character is held in s1; its result goes to the
//   output register as s1 advances; characters with no result leave nothing
// throughput: one character per cycle; stalls only while a result waits in
//   the output register
// reset: arst_n clears all parse state and sets memory_limit to 128000
module srecord_loader_parser #(
	parameter int unsigned ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	slp_char_if.sink    chars,
	slp_result_if.source results,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import slp_pkg::*;

	logic        vld_s1;
	logic [7:0]  ch_s1;
	logic        adv_s1;
	logic        res_vld_s2;
	result_t     res_s2;
	logic [31:0] memory_limit_q;
	core_out_t   core_out;

	assign adv_s1      = vld_s1 && (!res_vld_s2 || results.ready);
	assign chars.ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_limit_q <= MEM_LIMIT_RST;
		end else if (cfg_we) begin
			memory_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) ch_s1 <= chars.ch;
	end

	slp_core #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.ch           (ch_s1),
		.memory_limit (memory_limit_q),
		.core_out     (core_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_vld_s2 <= core_out.valid;
		end else if (results.ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= core_out.res;
	end

	assign results.valid          = res_vld_s2;
	assign results.kind           = res_s2.kind;
	assign results.target_address = res_s2.target_address;
	assign results.write_data     = res_s2.write_data;

`ifndef SYNTHESIS
	// a halted parser produces nothing
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		core_out.halted |-> !core_out.valid)
		else $error("result produced while halted");

	// only reset leaves the halted state
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		core_out.halted |=> core_out.halted)
		else $error("halt released without reset");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.kind != KIND_WRITE |-> results.write_data == 8'd0)
		else $error("nonzero data on a non-write result");

	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.kind == KIND_BAD_START || results.kind == KIND_BAD_TYPE
		|| results.kind == KIND_DATA_OVF || results.kind == KIND_ENTRY_OVF
		|| results.kind == KIND_BAD_COUNT) |-> results.target_address == 32'd0)
		else $error("nonzero address on an error result");
`endif

endmodule
